[rtl/sorted_table_binary_search_defines.svh]
// assertion macros for the sorted table binary search block
// expects clk and rst_n in the scope of use
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// same-cycle implication, reset masked
`define STBS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stbs assertion failed");

// next-cycle implication, reset masked
`define STBS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stbs assertion failed");

`endif

[rtl/stbs_pkg.sv]
// shared types and constants for the sorted table binary search block
// no dependencies
`timescale 1ns / 1ps

package stbs_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 128;
    localparam int KEY_W   = 32;
    localparam int INDEX_W = 7;
    localparam int SIZE_W  = 8;
    localparam int POS_W   = 7;

    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_RESULT
    } state_t;

    typedef struct packed
    {
        logic             found;
        logic [POS_W-1:0] position;
    } result_t;

endpackage

[rtl/stbs_mem.sv]
// table memory: one write port, one read port with registered read data
// depends on stbs_pkg
`timescale 1ns / 1ps

module stbs_mem #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  logic                               clk,
    input  logic                               we,
    input  logic [ADDR_W-1:0]                  waddr,
    input  logic signed [stbs_pkg::KEY_W-1:0]  wdata,
    input  logic                               re,
    input  logic [ADDR_W-1:0]                  raddr,
    output logic signed [stbs_pkg::KEY_W-1:0]  rdata
);

    logic signed [stbs_pkg::KEY_W-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/stbs_ctrl.sv]
// search sequencer: size register, probe window, compare and result register
// depends on stbs_pkg
`timescale 1ns / 1ps

module stbs_ctrl #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH),
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [stbs_pkg::SIZE_W-1:0]        cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               op,
    input  logic [stbs_pkg::INDEX_W-1:0]       entry_index,
    input  logic signed [stbs_pkg::KEY_W-1:0]  entry_value,
    input  logic signed [stbs_pkg::KEY_W-1:0]  search_key,
    output logic                               mem_we,
    output logic [ADDR_W-1:0]                  mem_waddr,
    output logic signed [stbs_pkg::KEY_W-1:0]  mem_wdata,
    output logic                               mem_re,
    output logic [ADDR_W-1:0]                  mem_raddr,
    input  logic signed [stbs_pkg::KEY_W-1:0]  mem_rdata,
    output logic                               out_valid,
    input  logic                               out_ready,
    output stbs_pkg::result_t                  result
);

    stbs_pkg::state_t state_reg, state_next;

    logic [stbs_pkg::SIZE_W-1:0]       size_reg;
    logic [CNT_W-1:0]                  lo_reg, lo_next;
    logic [CNT_W-1:0]                  hi_reg, hi_next;
    logic signed [stbs_pkg::KEY_W-1:0] key_reg, key_next;
    stbs_pkg::result_t                 res_reg, res_next;
    logic                              out_valid_reg, out_valid_next;
    stbs_pkg::result_t                 out_reg, out_next;

    logic              accept;
    logic [31:0]       idx_wide;
    logic [31:0]       size_wide;
    logic [31:0]       size_sat;
    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid;
    logic [CNT_W-1:0]  mid_inc;
    logic [31:0]       mid_wide;
    logic              load_out;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
        end
    end

    assign in_ready = (state_reg == stbs_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    // write path straight to the memory
    assign idx_wide  = 32'(entry_index);
    assign mem_we    = accept && (op == stbs_pkg::OP_WRITE) && (idx_wide < 32'(TABLE_DEPTH));
    assign mem_waddr = idx_wide[ADDR_W-1:0];
    assign mem_wdata = entry_value;

    // size saturated to the table depth
    assign size_wide = 32'(size_reg);
    assign size_sat  = (size_wide > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : size_wide;

    // midpoint of the window lo .. hi-1
    assign mid_sum   = (CNT_W + 1)'(lo_reg) + (CNT_W + 1)'(hi_reg) - (CNT_W + 1)'(1);
    assign mid       = mid_sum[CNT_W:1];
    assign mid_inc   = mid + CNT_W'(1);
    assign mid_wide  = 32'(mid);
    assign mem_re    = (state_reg == stbs_pkg::ST_PROBE);
    assign mem_raddr = mid[ADDR_W-1:0];

    assign load_out = (state_reg == stbs_pkg::ST_RESULT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            stbs_pkg::ST_IDLE:
            begin
                if (accept && (op == stbs_pkg::OP_SEARCH))
                begin
                    key_next = search_key;
                    lo_next  = '0;
                    hi_next  = size_sat[CNT_W-1:0];
                    res_next = '0;
                    if (size_sat == 32'd0)
                    begin
                        state_next = stbs_pkg::ST_RESULT;
                    end
                    else
                    begin
                        state_next = stbs_pkg::ST_PROBE;
                    end
                end
            end
            stbs_pkg::ST_PROBE:
            begin
                state_next = stbs_pkg::ST_COMPARE;
            end
            stbs_pkg::ST_COMPARE:
            begin
                if (key_reg == mem_rdata)
                begin
                    res_next.found    = 1'b1;
                    res_next.position = mid_wide[stbs_pkg::POS_W-1:0];
                    state_next        = stbs_pkg::ST_RESULT;
                end
                else
                begin
                    if (key_reg < mem_rdata)
                    begin
                        hi_next = mid;
                    end
                    else
                    begin
                        lo_next = mid_inc;
                    end
                    if (lo_next >= hi_next)
                    begin
                        state_next = stbs_pkg::ST_RESULT;
                    end
                    else
                    begin
                        state_next = stbs_pkg::ST_PROBE;
                    end
                end
            end
            stbs_pkg::ST_RESULT:
            begin
                if (load_out)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = stbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stbs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        key_reg <= key_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

endmodule

[rtl/sorted_table_binary_search.sv]
// Write request: taken when idle and written straight to the memory, no response.
// Search request: each probe is a memory read (PROBE), then a compare (COMPARE), at most
// floor(log2(size)) + 1 probes, then the response is registered from RESULT (entered directly
// on an empty table); RESULT waits while a held response is not taken, then returns to idle.
// rst_n clears the size register and control; table contents stay undefined until written.
// top level of the sorted table binary search block; depends on stbs_pkg
`timescale 1ns / 1ps

module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [stbs_pkg::SIZE_W-1:0]        cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               op,
    input  logic [stbs_pkg::INDEX_W-1:0]       entry_index,
    input  logic signed [stbs_pkg::KEY_W-1:0]  entry_value,
    input  logic signed [stbs_pkg::KEY_W-1:0]  search_key,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               found,
    output logic [stbs_pkg::POS_W-1:0]         position
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    logic                              mem_we;
    logic [ADDR_W-1:0]                 mem_waddr;
    logic signed [stbs_pkg::KEY_W-1:0] mem_wdata;
    logic                              mem_re;
    logic [ADDR_W-1:0]                 mem_raddr;
    logic signed [stbs_pkg::KEY_W-1:0] mem_rdata;
    stbs_pkg::result_t                 result;

    stbs_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result      (result)
    );

    stbs_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign found    = result.found;
    assign position = result.position;

endmodule

[rtl/stbs_checker.sv]
// port-level checks for the sorted table binary search block, with bind
// depends on stbs_pkg and sorted_table_binary_search_defines.svh
`timescale 1ns / 1ps
`include "sorted_table_binary_search_defines.svh"

module stbs_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               op,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic                               found,
    input logic [stbs_pkg::POS_W-1:0]         position
);

    // held response keeps its payload
    `STBS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(found) && $stable(position))
    // a miss reports position zero
    `STBS_ASSERT_IMP(a_miss_pos, out_valid && !found, position == '0)
    // a search request keeps the block busy for at least the next cycle
    `STBS_ASSERT_NXT(a_search_busy, in_valid && in_ready && (op == stbs_pkg::OP_SEARCH), !in_ready)
    // a write request completes at once
    `STBS_ASSERT_NXT(a_write_free, in_valid && in_ready && (op == stbs_pkg::OP_WRITE), in_ready)

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);
